### hdl/dstwr_pkg.sv
package dstwr_pkg;

  localparam int unsigned IN_TS_W   = 40;
  localparam int unsigned TOF_W     = 48;
  localparam int unsigned DIST_W    = 32;
  localparam int unsigned ST_W      = 2;

  // one tick in mm = 149896229 / (975 * 2^15)
  localparam int unsigned    TICK_NUM_W     = 28;
  localparam logic [27:0]    TICK_MM_NUM    = 28'd149896229;
  localparam int unsigned    TICK_ODD_W     = 10;
  localparam logic [9:0]     TICK_DEN_ODD   = 10'd975;
  localparam int unsigned    TICK_DEN_SHIFT = 15;

  // ceil(2^52 / 975): exact floor(x / 975) for every x below 975 * 2^32
  localparam int unsigned    RECIP_W        = 43;
  localparam int unsigned    RECIP_SHIFT    = 52;
  localparam logic [42:0]    TICK_DEN_RECIP = 43'd4619076540893;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_NUM  = 2'd1,
    ST_ZERO_DEN = 2'd2
  } status_t;

  typedef struct packed {
    logic [IN_TS_W-1:0] poll_tx_time;
    logic [IN_TS_W-1:0] resp_rx_time;
    logic [IN_TS_W-1:0] final_tx_time;
    logic [IN_TS_W-1:0] poll_rx_time;
    logic [IN_TS_W-1:0] resp_tx_time;
    logic [IN_TS_W-1:0] final_rx_time;
  } in_t;

  typedef struct packed {
    logic [TOF_W-1:0]  tof_ticks_q8;
    logic [DIST_W-1:0] distance_mm;
    logic [ST_W-1:0]   status;
  } out_t;

endpackage

### hdl/dstwr_front.sv
module dstwr_front #(
  parameter int unsigned TB = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dstwr_pkg::in_t      in_req,
  input  logic                in_push,
  output logic                in_full,
  input  logic                deq,
  output logic                deq_empty,
  output logic [4*TB-1:0]     deq_data
);

  localparam int unsigned DEPTH = 4;

  logic [TB+dstwr_pkg::IN_TS_W-1:0] t0, t1, t2, t3, t4, t5;
  logic [TB-1:0] ra, da, db, rb;

  logic [4*TB-1:0] q_mem_r [DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  // take the low TB bits of each timestamp, zero padded if TB is wide
  assign t0 = {{TB{1'b0}}, in_req.poll_tx_time};
  assign t1 = {{TB{1'b0}}, in_req.resp_rx_time};
  assign t2 = {{TB{1'b0}}, in_req.final_tx_time};
  assign t3 = {{TB{1'b0}}, in_req.poll_rx_time};
  assign t4 = {{TB{1'b0}}, in_req.resp_tx_time};
  assign t5 = {{TB{1'b0}}, in_req.final_rx_time};

  assign ra = t1[TB-1:0] - t0[TB-1:0];
  assign da = t2[TB-1:0] - t1[TB-1:0];
  assign db = t4[TB-1:0] - t3[TB-1:0];
  assign rb = t5[TB-1:0] - t4[TB-1:0];

  assign in_full   = (cnt_r == 3'(DEPTH));
  assign deq_empty = (cnt_r == 3'd0);
  assign wr_en     = in_push && !in_full;
  assign rd_en     = deq && !deq_empty;
  assign deq_data  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + 2'(wr_en);
    rd_ptr_nxt = rd_ptr_r + 2'(rd_en);
    cnt_nxt    = cnt_r + 3'(wr_en) - 3'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem_r[wr_ptr_r] <= {ra, da, db, rb};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(DEPTH))
    else $error("front queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> cnt_r == $past(cnt_r) + 3'd1)
    else $error("front queue lost a request");
  assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && !wr_en) |=> rd_ptr_r == $past(rd_ptr_r) + 2'd1)
    else $error("front queue read pointer did not advance");

endmodule

### hdl/dstwr_div.sv
module dstwr_div #(
  parameter int unsigned NW = 88,
  parameter int unsigned DW = 42,
  parameter int unsigned SW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  // one quotient bit per stage, numerator shifted out msb first
  logic          v_r    [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [NW-1:0] quot_r [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          src_v;
    logic [DW-1:0] src_rem;
    logic [NW-1:0] src_num;
    logic [NW-1:0] src_quot;
    logic [DW-1:0] src_den;
    logic [SW-1:0] src_side;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_rem  = '0;
      assign src_num  = in_num;
      assign src_quot = '0;
      assign src_den  = in_den;
      assign src_side = in_side;
    end else begin : g_next
      assign src_v    = v_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_num  = num_r[k-1];
      assign src_quot = quot_r[k-1];
      assign src_den  = den_r[k-1];
      assign src_side = side_r[k-1];
    end

    assign trial = {src_rem, src_num[NW-1]};
    assign ge    = (trial >= {1'b0, src_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? DW'(trial - {1'b0, src_den}) : DW'(trial);
        num_r[k]  <= src_num << 1;
        quot_r[k] <= {src_quot[NW-2:0], ge};
        den_r[k]  <= src_den;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quot  = quot_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

### hdl/dstwr_back.sv
module dstwr_back #(
  parameter int unsigned TB = 40,
  parameter int unsigned FB = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [4*TB-1:0]   iv_data,
  input  logic              iv_empty,
  output logic              iv_pop,
  input  logic              res_ready,
  output logic              res_valid,
  output dstwr_pkg::out_t   res
);

  localparam int unsigned H   = (TB + 1) / 2;
  localparam int unsigned PW  = 2 * TB;
  localparam int unsigned DW  = TB + 2;
  localparam int unsigned NW  = PW + FB;
  localparam int unsigned TW  = dstwr_pkg::TOF_W;
  localparam int unsigned TH  = TW / 2;
  localparam int unsigned KW  = dstwr_pkg::TICK_NUM_W;
  localparam int unsigned MW  = TW + KW;
  localparam int unsigned XW  = MW - dstwr_pkg::TICK_DEN_SHIFT - FB;
  localparam int unsigned SW  = dstwr_pkg::ST_W;
  localparam int unsigned DSW = dstwr_pkg::DIST_W;
  localparam int unsigned QW  = dstwr_pkg::TICK_ODD_W + DSW;
  localparam int unsigned QL  = QW / 2;
  localparam int unsigned RW  = dstwr_pkg::RECIP_W;
  localparam int unsigned PPW = QW - QL + RW - QL;
  localparam int unsigned RSW = QW + RW;
  localparam int unsigned RS  = dstwr_pkg::RECIP_SHIFT;
  localparam logic [RW-1:0] RC = dstwr_pkg::TICK_DEN_RECIP;

  logic adv;
  assign adv    = res_ready;
  assign iv_pop = adv && !iv_empty;

  // s1: interval values
  logic s1_v_r;
  logic [TB-1:0] ra_r, da_r, db_r, rb_r;

  // s2: partial products and denominator
  logic s2_v_r;
  logic [2*H-1:0] prll_r, prlh_r, prhl_r, prhh_r;
  logic [2*H-1:0] pdll_r, pdlh_r, pdhl_r, pdhh_r;
  logic [DW-1:0]  s2_den_r;
  logic [H-1:0]   ral, rah, rbl, rbh, dal, dah, dbl, dbh;
  logic [2*TB-1:0] ra_x, rb_x, da_x, db_x;

  // s3: full products
  logic s3_v_r;
  logic [PW-1:0] pr_r, pd_r;
  logic [DW-1:0] s3_den_r;
  logic [4*H-1:0] pr_sum, pd_sum;

  // s4: numerator and classification
  logic s4_v_r;
  logic [NW-1:0] s4_num_r;
  logic [DW-1:0] s4_den_r;
  dstwr_pkg::status_t s4_st_r, s4_st_nxt;

  logic          d1_v;
  logic [NW-1:0] d1_q;
  logic [SW-1:0] d1_side;

  // s5: clamped tof and distance partial products
  logic s5_v_r;
  logic [TW-1:0] s5_tof_r;
  logic [SW-1:0] s5_st_r;
  logic [TH+KW-1:0] dp_lo_r, dp_hi_r;
  logic [NW+TW-1:0] d1_qx;
  logic [TW-1:0] tof_sat;

  // s6: scaled distance ahead of divide by the odd factor
  logic s6_v_r;
  logic [XW-1:0] s6_x_r;
  logic [TW-1:0] s6_tof_r;
  logic [SW-1:0] s6_st_r;
  logic [MW-1:0] dp_sum;

  // s7: saturation check and reciprocal partial products for the divide by 975
  logic s7_v_r;
  logic s7_sat_r;
  logic [TW-1:0] s7_tof_r;
  logic [SW-1:0] s7_st_r;
  logic [PPW-1:0] rp_ll_r, rp_lh_r, rp_hl_r, rp_hh_r;
  logic [QL-1:0] x_lo;
  logic [QW-QL-1:0] x_hi;
  logic [QL-1:0] rc_lo;
  logic [RW-QL-1:0] rc_hi;

  // s8: distance
  logic s8_v_r;
  logic [TW-1:0] s8_tof_r;
  logic [SW-1:0] s8_st_r;
  logic [DSW-1:0] s8_dist_r;
  logic [RSW-1:0] rp_sum;

  always_comb begin
    ra_x = {{TB{1'b0}}, ra_r};
    rb_x = {{TB{1'b0}}, rb_r};
    da_x = {{TB{1'b0}}, da_r};
    db_x = {{TB{1'b0}}, db_r};
    ral  = ra_x[H-1:0];
    rah  = ra_x[2*H-1:H];
    rbl  = rb_x[H-1:0];
    rbh  = rb_x[2*H-1:H];
    dal  = da_x[H-1:0];
    dah  = da_x[2*H-1:H];
    dbl  = db_x[H-1:0];
    dbh  = db_x[2*H-1:H];
  end

  always_comb begin
    pr_sum = {{2*H{1'b0}}, prll_r}
           + ({{2*H{1'b0}}, prlh_r} << H)
           + ({{2*H{1'b0}}, prhl_r} << H)
           + ({{2*H{1'b0}}, prhh_r} << (2*H));
    pd_sum = {{2*H{1'b0}}, pdll_r}
           + ({{2*H{1'b0}}, pdlh_r} << H)
           + ({{2*H{1'b0}}, pdhl_r} << H)
           + ({{2*H{1'b0}}, pdhh_r} << (2*H));
  end

  always_comb begin
    if (s3_den_r == '0) begin
      s4_st_nxt = dstwr_pkg::ST_ZERO_DEN;
    end else if (pr_r < pd_r) begin
      s4_st_nxt = dstwr_pkg::ST_NEG_NUM;
    end else begin
      s4_st_nxt = dstwr_pkg::ST_OK;
    end
  end

  always_comb begin
    d1_qx   = {{TW{1'b0}}, d1_q};
    tof_sat = (|d1_qx[NW+TW-1:TW]) ? {TW{1'b1}} : d1_qx[TW-1:0];
    if (dstwr_pkg::status_t'(d1_side) != dstwr_pkg::ST_OK) begin
      tof_sat = '0;
    end
    dp_sum = {{(MW-TH-KW){1'b0}}, dp_lo_r}
           + ({{(MW-TH-KW){1'b0}}, dp_hi_r} << TH);
  end

  always_comb begin
    x_lo   = s6_x_r[QL-1:0];
    x_hi   = s6_x_r[QW-1:QL];
    rc_lo  = RC[QL-1:0];
    rc_hi  = RC[RW-1:QL];
    rp_sum = RSW'(rp_ll_r)
           + (RSW'(rp_lh_r) << QL)
           + (RSW'(rp_hl_r) << QL)
           + (RSW'(rp_hh_r) << (2*QL));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= !iv_empty;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= d1_v;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {ra_r, da_r, db_r, rb_r} <= iv_data;

      prll_r   <= ral * rbl;
      prlh_r   <= ral * rbh;
      prhl_r   <= rah * rbl;
      prhh_r   <= rah * rbh;
      pdll_r   <= dal * dbl;
      pdlh_r   <= dal * dbh;
      pdhl_r   <= dah * dbl;
      pdhh_r   <= dah * dbh;
      s2_den_r <= DW'(ra_r) + DW'(da_r) + DW'(db_r) + DW'(rb_r);

      pr_r     <= pr_sum[PW-1:0];
      pd_r     <= pd_sum[PW-1:0];
      s3_den_r <= s2_den_r;

      s4_st_r  <= s4_st_nxt;
      s4_den_r <= s3_den_r;
      s4_num_r <= (s4_st_nxt == dstwr_pkg::ST_OK) ? (NW'(pr_r - pd_r) << FB) : '0;

      s5_tof_r <= tof_sat;
      s5_st_r  <= d1_side;
      dp_lo_r  <= tof_sat[TH-1:0] * dstwr_pkg::TICK_MM_NUM;
      dp_hi_r  <= tof_sat[TW-1:TH] * dstwr_pkg::TICK_MM_NUM;

      s6_x_r   <= XW'(dp_sum >> (dstwr_pkg::TICK_DEN_SHIFT + FB));
      s6_tof_r <= s5_tof_r;
      s6_st_r  <= s5_st_r;

      // quotient reaches 2^32 exactly when x reaches 975 * 2^32
      s7_sat_r <= (s6_x_r >= XW'({dstwr_pkg::TICK_DEN_ODD, {DSW{1'b0}}}));
      s7_tof_r <= s6_tof_r;
      s7_st_r  <= s6_st_r;
      rp_ll_r  <= x_lo * rc_lo;
      rp_lh_r  <= x_lo * rc_hi;
      rp_hl_r  <= x_hi * rc_lo;
      rp_hh_r  <= x_hi * rc_hi;

      s8_dist_r <= s7_sat_r ? {DSW{1'b1}} : rp_sum[RS +: DSW];
      s8_tof_r  <= s7_tof_r;
      s8_st_r   <= s7_st_r;
    end
  end

  dstwr_div #(.NW(NW), .DW(DW), .SW(SW)) u_tof_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s4_v_r),
    .in_num   (s4_num_r),
    .in_den   (s4_den_r),
    .in_side  (SW'(s4_st_r)),
    .out_valid(d1_v),
    .out_quot (d1_q),
    .out_side (d1_side)
  );

  assign res_valid        = s8_v_r;
  assign res.tof_ticks_q8 = s8_tof_r;
  assign res.status       = s8_st_r;
  assign res.distance_mm  = s8_dist_r;

endmodule

### hdl/ds_twr_time_of_flight_unit.sv
// channel   ports                          direction  payload
// input     in_push, in_full, in_req       in         dstwr_pkg::in_t
// result    out_pop, out_empty, out_rsp    out        dstwr_pkg::out_t
//
// One request is taken per cycle while in_full is low; results come out in order.
// A request accepted into the front queue passes through back stages s1 to s4,
// the bit-per-stage tof divider, stages s5 to s8 and the result queue before it
// shows on out_rsp; the divide by 975 is a reciprocal multiply over s7 and s8.
// rst_n is synchronous and clears only the queue and pipeline valid bits.
// A full result queue freezes the whole back pipeline; the front queue keeps
// taking requests until its four entries fill.
module ds_twr_time_of_flight_unit #(
  parameter int unsigned TIMESTAMP_BITS = 40,
  parameter int unsigned FRAC_BITS      = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dstwr_pkg::in_t   in_req,
  input  logic             in_push,
  output logic             in_full,
  output dstwr_pkg::out_t  out_rsp,
  output logic             out_empty,
  input  logic             out_pop
);

  logic [4*TIMESTAMP_BITS-1:0] iv_data;
  logic iv_empty, iv_pop;
  logic res_valid, res_ready;
  dstwr_pkg::out_t res;

  dstwr_pkg::out_t oq_mem_r [2];
  logic oq_wr_r, oq_rd_r;
  logic [1:0] oq_cnt_r, oq_cnt_nxt;
  logic oq_push, oq_take;

  dstwr_front #(.TB(TIMESTAMP_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .in_push  (in_push),
    .in_full  (in_full),
    .deq      (iv_pop),
    .deq_empty(iv_empty),
    .deq_data (iv_data)
  );

  dstwr_back #(.TB(TIMESTAMP_BITS), .FB(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .iv_data  (iv_data),
    .iv_empty (iv_empty),
    .iv_pop   (iv_pop),
    .res_ready(res_ready),
    .res_valid(res_valid),
    .res      (res)
  );

  assign res_ready  = (oq_cnt_r != 2'd2);
  assign oq_push    = res_valid && res_ready;
  assign out_empty  = (oq_cnt_r == 2'd0);
  assign oq_take    = out_pop && !out_empty;
  assign out_rsp    = oq_mem_r[oq_rd_r];
  assign oq_cnt_nxt = oq_cnt_r + 2'(oq_push) - 2'(oq_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      oq_wr_r  <= oq_wr_r ^ oq_push;
      oq_rd_r  <= oq_rd_r ^ oq_take;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) oq_cnt_r != 2'd3)
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !iv_empty)
    else $error("accepted request not visible to back end");
  assert property (@(posedge clk) disable iff (!rst_n)
    (!res_ready && res_valid) |=> res_valid && $stable(res))
    else $error("stalled result changed");

endmodule
